### hdl/s2eig_pkg.sv
package s2eig_pkg;

  localparam int ROOT_ITERATIONS_DEF = 24;
  localparam int FRAC_BITS = 60;
  localparam int QUARTER_W = 64;
  localparam int DIV_W = 34;
  localparam int BIG_W = 31;
  localparam logic [23:0] TOL_SCALE = 24'd10000000;
  localparam logic [BIG_W-1:0] ONE_Q30 = 31'h4000_0000;
  localparam logic [32:0] EIG_MAX = 33'h0_FFFF_FFFF;
  localparam logic [32:0] EIG_MIN = 33'h1_0000_0000;

  typedef struct packed {
    logic        diag;
    logic        age;
    logic        cneg;
    logic [1:0]  lowbits;
    logic [31:0] ad;
    logic [31:0] ac;
    logic [32:0] sum_ab;
    logic [31:0] mx;
    logic [31:0] mn;
  } side_root_t;

  typedef struct packed {
    logic        diag;
    logic        age;
    logic        cneg;
    logic [32:0] major;
    logic [32:0] minor;
  } side_eig_t;

  typedef struct packed {
    side_eig_t               eig;
    logic [FRAC_BITS:0]      frac;
  } side_frac_t;

  typedef struct packed {
    side_eig_t               eig;
    logic [BIG_W-1:0]        big;
  } side_big_t;

  // floor of s/2, saturated to 33 bits signed
  function automatic logic [32:0] sat_half(logic signed [34:0] s);
    logic signed [34:0] h;
    logic [32:0] r;
    h = s >>> 1;
    if ((h[34] == h[33]) && (h[33] == h[32])) begin
      r = h[32:0];
    end else if (h[34]) begin
      r = EIG_MIN;
    end else begin
      r = EIG_MAX;
    end
    return r;
  endfunction

endpackage

### hdl/s2eig_delay.sv
module s2eig_delay #(
  parameter int W     = 8,
  parameter int DEPTH = 1
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         vld_i,
  input  logic [W-1:0] data_i,
  output logic         vld_o,
  output logic [W-1:0] data_o
);

  logic [W-1:0] data_q [DEPTH];
  logic [DEPTH-1:0] vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= DEPTH'({vld_q, vld_i});
    end
  end

  always_ff @(posedge clk_i) begin
    data_q[0] <= data_i;
  end

  for (genvar k = 1; k < DEPTH; k++) begin : g_tap
    always_ff @(posedge clk_i) begin
      data_q[k] <= data_q[k-1];
    end
  end

  assign vld_o  = vld_q[DEPTH-1];
  assign data_o = data_q[DEPTH-1];

endmodule

### hdl/s2eig_isqrt.sv
module s2eig_isqrt #(
  parameter int W = 64
) (
  input  logic           clk_i,
  input  logic [W-1:0]   x_i,
  output logic [W/2-1:0] root_o,
  output logic [W/2:0]   rem_o
);

  localparam int N = W / 2;

  logic [W-1:0] x_q   [N+1];
  logic [W-1:0] res_q [N+1];

  always_ff @(posedge clk_i) begin
    x_q[0]   <= x_i;
    res_q[0] <= '0;
  end

  // one result bit per stage
  for (genvar k = 0; k < N; k++) begin : g_step
    localparam logic [W-1:0] BIT = {{(W-1){1'b0}}, 1'b1} << (W - 2 - 2 * k);
    logic [W-1:0] trial;
    logic         ge;
    logic [W-1:0] x_d;
    logic [W-1:0] res_d;

    always_comb begin
      trial = res_q[k] + BIT;
      ge    = x_q[k] >= trial;
      x_d   = ge ? (x_q[k] - trial) : x_q[k];
      res_d = ge ? ((res_q[k] >> 1) + BIT) : (res_q[k] >> 1);
    end

    always_ff @(posedge clk_i) begin
      x_q[k+1]   <= x_d;
      res_q[k+1] <= res_d;
    end
  end

  assign root_o = res_q[N][N-1:0];
  assign rem_o  = x_q[N][N:0];

endmodule

### hdl/s2eig_fdiv.sv
module s2eig_fdiv #(
  parameter int W  = 34,
  parameter int QB = 60
) (
  input  logic         clk_i,
  input  logic [W-1:0] num_i,
  input  logic [W-1:0] den_i,
  output logic [QB:0]  quo_o
);

  localparam int N = QB + 1;

  logic [W-1:0] rem_q [N+1];
  logic [W-1:0] den_q [N+1];
  logic [QB:0]  quo_q [N+1];

  always_ff @(posedge clk_i) begin
    rem_q[0] <= num_i;
    den_q[0] <= den_i;
    quo_q[0] <= '0;
  end

  // restoring division, integer bit first, then one fraction bit per stage
  for (genvar k = 0; k < N; k++) begin : g_step
    logic [W:0]   trial;
    logic         ge;
    logic [W-1:0] rem_d;
    logic [QB:0]  quo_d;

    always_comb begin
      if (k == 0) begin
        trial = {1'b0, rem_q[k]};
      end else begin
        trial = {rem_q[k], 1'b0};
      end
      ge    = trial >= {1'b0, den_q[k]};
      rem_d = ge ? W'(trial - {1'b0, den_q[k]}) : trial[W-1:0];
      quo_d = {quo_q[k][QB-1:0], ge};
    end

    always_ff @(posedge clk_i) begin
      rem_q[k+1] <= rem_d;
      den_q[k+1] <= den_q[k];
      quo_q[k+1] <= quo_d;
    end
  end

  assign quo_o = quo_q[N];

endmodule

### hdl/s2eig_sdiv.sv
module s2eig_sdiv #(
  parameter int NW = 61,
  parameter int DW = 31,
  parameter int QW = 31
) (
  input  logic          clk_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output logic [QW-1:0] quo_o,
  output logic          ovf_o
);

  localparam int N  = QW + 1;
  localparam int CW = DW + QW;

  logic [NW-1:0] rem_q [N+1];
  logic [DW-1:0] den_q [N+1];
  logic [QW-1:0] quo_q [N+1];
  logic          ovf_q [N+1];

  always_ff @(posedge clk_i) begin
    rem_q[0] <= num_i;
    den_q[0] <= den_i;
    quo_q[0] <= '0;
    ovf_q[0] <= 1'b0;
  end

  // first stage flags a quotient beyond QW bits, then one quotient bit per stage
  for (genvar k = 0; k < N; k++) begin : g_step
    logic [CW-1:0] rem_ext;
    logic [CW-1:0] sh;
    logic          ge;
    logic [NW-1:0] rem_d;
    logic [QW-1:0] quo_d;
    logic          ovf_d;

    always_comb begin
      rem_ext = CW'(rem_q[k]);
      quo_d   = quo_q[k];
      ovf_d   = ovf_q[k];
      rem_d   = rem_q[k];
      if (k == 0) begin
        sh    = {den_q[k], {QW{1'b0}}};
        ge    = rem_ext >= sh;
        ovf_d = ge;
      end else begin
        sh = CW'(den_q[k]) << (QW - k);
        ge = rem_ext >= sh;
        if (ge) begin
          rem_d = NW'(rem_ext - sh);
        end
        quo_d[QW-k] = ge;
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[k+1] <= rem_d;
      den_q[k+1] <= den_q[k];
      quo_q[k+1] <= quo_d;
      ovf_q[k+1] <= ovf_d;
    end
  end

  assign quo_o = quo_q[N];
  assign ovf_o = ovf_q[N];

endmodule

### hdl/sym_2x2_eigen_decompose.sv
// each accepted start yields one valid_o strobe
// throughput: one matrix per cycle; busy stays low, a start is taken every cycle
// the latency is set by the bit-per-stage root, divider and quotient pipelines
// reset clears all valid bits at once; datapath registers are not reset
// the receiver cannot stall, results appear for a single cycle
module sym_2x2_eigen_decompose #(
  parameter int ROOT_ITERATIONS = s2eig_pkg::ROOT_ITERATIONS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] diag_first_i,
  input  logic [31:0] diag_second_i,
  input  logic [31:0] off_diag_i,
  output logic        valid_o,
  output logic [32:0] eigen_major_o,
  output logic [32:0] eigen_minor_o,
  output logic [31:0] vec_row0_col0_o,
  output logic [31:0] vec_row0_col1_o,
  output logic [31:0] vec_row1_col0_o,
  output logic [31:0] vec_row1_col1_o
);

  localparam int PREC = (ROOT_ITERATIONS > 30) ? 30 : ROOT_ITERATIONS;
  localparam logic [s2eig_pkg::BIG_W-1:0] CLR_MASK =
    s2eig_pkg::BIG_W'((64'd1 << (30 - PREC)) - 64'd1);
  localparam int ISQ1_LAT = s2eig_pkg::QUARTER_W / 2 + 1;
  localparam int DIV_LAT  = s2eig_pkg::FRAC_BITS + 2;
  localparam int ISQ2_W   = s2eig_pkg::FRAC_BITS + 2;
  localparam int ISQ2_LAT = ISQ2_W / 2 + 1;
  localparam int SDIV_LAT = s2eig_pkg::BIG_W + 2;
  localparam int TOTAL_LAT = 4 + ISQ1_LAT + 1 + DIV_LAT + ISQ2_LAT + 1 + SDIV_LAT + 1;

  assign busy = 1'b0;

  // input register
  logic               vld0_q;
  logic signed [31:0] a0_q, b0_q, c0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld0_q <= 1'b0;
    end else begin
      vld0_q <= start && !busy;
    end
  end

  always_ff @(posedge clk_i) begin
    a0_q <= diag_first_i;
    b0_q <= diag_second_i;
    c0_q <= off_diag_i;
  end

  // magnitudes, sums and ordering
  logic        vld1_q;
  logic [31:0] ad1_q, ac1_q, absa1_q, absb1_q, mx1_q, mn1_q;
  logic [32:0] sumab1_q;
  logic        age1_q, cneg1_q, cz1_q;
  logic [32:0] diff1_d;
  logic        age1_d;

  always_comb begin
    diff1_d = {a0_q[31], a0_q} - {b0_q[31], b0_q};
    age1_d  = a0_q >= b0_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
    end else begin
      vld1_q <= vld0_q;
    end
  end

  always_ff @(posedge clk_i) begin
    ad1_q    <= diff1_d[32] ? 32'(-diff1_d) : diff1_d[31:0];
    ac1_q    <= c0_q[31] ? (~c0_q + 32'd1) : c0_q;
    absa1_q  <= a0_q[31] ? (~a0_q + 32'd1) : a0_q;
    absb1_q  <= b0_q[31] ? (~b0_q + 32'd1) : b0_q;
    sumab1_q <= {a0_q[31], a0_q} + {b0_q[31], b0_q};
    age1_q   <= age1_d;
    cneg1_q  <= c0_q[31];
    cz1_q    <= c0_q == 32'sd0;
    mx1_q    <= age1_d ? a0_q : b0_q;
    mn1_q    <= age1_d ? b0_q : a0_q;
  end

  // squares and tolerance product
  logic        vld2_q;
  logic [63:0] dsq2_q, csq2_q;
  logic [55:0] tolp2_q;
  logic [32:0] abssum2_q, sumab2_q;
  logic [31:0] ad2_q, ac2_q, mx2_q, mn2_q;
  logic        age2_q, cneg2_q, cz2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld2_q <= 1'b0;
    end else begin
      vld2_q <= vld1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    dsq2_q    <= 64'(ad1_q) * 64'(ad1_q);
    csq2_q    <= 64'(ac1_q) * 64'(ac1_q);
    tolp2_q   <= 56'(ac1_q) * 56'(s2eig_pkg::TOL_SCALE);
    abssum2_q <= {1'b0, absa1_q} + {1'b0, absb1_q};
    sumab2_q  <= sumab1_q;
    ad2_q     <= ad1_q;
    ac2_q     <= ac1_q;
    mx2_q     <= mx1_q;
    mn2_q     <= mn1_q;
    age2_q    <= age1_q;
    cneg2_q   <= cneg1_q;
    cz2_q     <= cz1_q;
  end

  // quarter of the discriminant, diagonal test
  logic                   vld3_q;
  logic [63:0]            quarter3_q;
  s2eig_pkg::side_root_t  side3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld3_q <= 1'b0;
    end else begin
      vld3_q <= vld2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    quarter3_q      <= {2'b00, dsq2_q[63:2]} + csq2_q;
    side3_q.diag    <= cz2_q || (tolp2_q < 56'(abssum2_q));
    side3_q.age     <= age2_q;
    side3_q.cneg    <= cneg2_q;
    side3_q.lowbits <= dsq2_q[1:0];
    side3_q.ad      <= ad2_q;
    side3_q.ac      <= ac2_q;
    side3_q.sum_ab  <= sumab2_q;
    side3_q.mx      <= mx2_q;
    side3_q.mn      <= mn2_q;
  end

  // square root of the discriminant
  logic [31:0]           root1;
  logic [32:0]           rem1;
  logic                  vld_r1;
  s2eig_pkg::side_root_t side_r1;

  s2eig_isqrt #(.W(s2eig_pkg::QUARTER_W)) u_isqrt_disc (
    .clk_i  (clk_i),
    .x_i    (quarter3_q),
    .root_o (root1),
    .rem_o  (rem1)
  );

  s2eig_delay #(.W($bits(s2eig_pkg::side_root_t)), .DEPTH(ISQ1_LAT)) u_dly_root (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (vld3_q),
    .data_i (side3_q),
    .vld_o  (vld_r1),
    .data_o (side_r1)
  );

  // rounded root and eigenvalues
  logic                  vld4_q;
  logic [32:0]           q4_q;
  logic [31:0]           ad4_q, ac4_q;
  s2eig_pkg::side_eig_t  eig4_q;
  logic                  inc4_d;
  logic [32:0]           q4_d;
  logic signed [34:0]    ext4_d, plus4_d, minus4_d;

  always_comb begin
    inc4_d   = ({1'b0, root1} < rem1) ||
               (({1'b0, root1} == rem1) && (side_r1.lowbits != 2'b00));
    q4_d     = {root1, inc4_d};
    ext4_d   = {{2{side_r1.sum_ab[32]}}, side_r1.sum_ab};
    plus4_d  = ext4_d + {2'b00, q4_d};
    minus4_d = ext4_d - {2'b00, q4_d};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld4_q <= 1'b0;
    end else begin
      vld4_q <= vld_r1;
    end
  end

  always_ff @(posedge clk_i) begin
    q4_q        <= q4_d;
    ad4_q       <= side_r1.ad;
    ac4_q       <= side_r1.ac;
    eig4_q.diag <= side_r1.diag;
    eig4_q.age  <= side_r1.age;
    eig4_q.cneg <= side_r1.cneg;
    if (side_r1.diag) begin
      eig4_q.major <= {side_r1.mx[31], side_r1.mx};
      eig4_q.minor <= {side_r1.mn[31], side_r1.mn};
    end else begin
      eig4_q.major <= s2eig_pkg::sat_half(plus4_d);
      eig4_q.minor <= s2eig_pkg::sat_half(minus4_d);
    end
  end

  // (q + |d|) / 2q and |c| / q as Q1.60
  logic [s2eig_pkg::FRAC_BITS:0] frac_big, frac_small;
  logic                          vld_dv;
  s2eig_pkg::side_eig_t          eig_dv;
  s2eig_pkg::side_frac_t         sidef_d, sidef_dly;
  logic                          vld_fr;

  s2eig_fdiv #(.W(s2eig_pkg::DIV_W), .QB(s2eig_pkg::FRAC_BITS)) u_fdiv_cos (
    .clk_i (clk_i),
    .num_i ({1'b0, q4_q} + {2'b00, ad4_q}),
    .den_i ({q4_q, 1'b0}),
    .quo_o (frac_big)
  );

  s2eig_fdiv #(.W(s2eig_pkg::DIV_W), .QB(s2eig_pkg::FRAC_BITS)) u_fdiv_sin (
    .clk_i (clk_i),
    .num_i ({2'b00, ac4_q}),
    .den_i ({1'b0, q4_q}),
    .quo_o (frac_small)
  );

  s2eig_delay #(.W($bits(s2eig_pkg::side_eig_t)), .DEPTH(DIV_LAT)) u_dly_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (vld4_q),
    .data_i (eig4_q),
    .vld_o  (vld_dv),
    .data_o (eig_dv)
  );

  // larger component as a square root
  logic [s2eig_pkg::BIG_W-1:0] root2;

  assign sidef_d.eig  = eig_dv;
  assign sidef_d.frac = frac_small;

  s2eig_isqrt #(.W(ISQ2_W)) u_isqrt_big (
    .clk_i  (clk_i),
    .x_i    ({1'b0, frac_big}),
    .root_o (root2),
    .rem_o  ()
  );

  s2eig_delay #(.W($bits(s2eig_pkg::side_frac_t)), .DEPTH(ISQ2_LAT)) u_dly_big (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (vld_dv),
    .data_i (sidef_d),
    .vld_o  (vld_fr),
    .data_o (sidef_dly)
  );

  // precision mask and clamp
  logic                        vld5_q;
  s2eig_pkg::side_big_t        sideb5_q;
  logic [s2eig_pkg::FRAC_BITS:0] fsm5_q;
  logic [s2eig_pkg::BIG_W-1:0] big5_d;

  always_comb begin
    big5_d = root2 & ~CLR_MASK;
    if (big5_d > s2eig_pkg::ONE_Q30) begin
      big5_d = s2eig_pkg::ONE_Q30;
    end
    if (big5_d == '0) begin
      big5_d = s2eig_pkg::BIG_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld5_q <= 1'b0;
    end else begin
      vld5_q <= vld_fr;
    end
  end

  always_ff @(posedge clk_i) begin
    sideb5_q.eig <= sidef_dly.eig;
    sideb5_q.big <= big5_d;
    fsm5_q       <= sidef_dly.frac;
  end

  // smaller component as a quotient
  logic [s2eig_pkg::BIG_W-1:0] quo6;
  logic                        ovf6;
  logic                        vld_sd;
  s2eig_pkg::side_big_t        sideb_sd;

  s2eig_sdiv #(
    .NW(s2eig_pkg::FRAC_BITS + 1),
    .DW(s2eig_pkg::BIG_W),
    .QW(s2eig_pkg::BIG_W)
  ) u_sdiv (
    .clk_i (clk_i),
    .num_i (fsm5_q),
    .den_i (sideb5_q.big),
    .quo_o (quo6),
    .ovf_o (ovf6)
  );

  s2eig_delay #(.W($bits(s2eig_pkg::side_big_t)), .DEPTH(SDIV_LAT)) u_dly_sdiv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (vld5_q),
    .data_i (sideb5_q),
    .vld_o  (vld_sd),
    .data_o (sideb_sd)
  );

  // output register
  logic [s2eig_pkg::BIG_W-1:0] small6_d;
  logic [31:0]                 cs6_d, snm6_d, sn6_d;
  logic [31:0]                 one32;

  always_comb begin
    one32    = {1'b0, s2eig_pkg::ONE_Q30};
    small6_d = (ovf6 || (quo6 > s2eig_pkg::ONE_Q30)) ? s2eig_pkg::ONE_Q30 : quo6;
    cs6_d    = sideb_sd.eig.age ? {1'b0, sideb_sd.big} : {1'b0, small6_d};
    snm6_d   = sideb_sd.eig.age ? {1'b0, small6_d} : {1'b0, sideb_sd.big};
    sn6_d    = sideb_sd.eig.cneg ? (~snm6_d + 32'd1) : snm6_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else begin
      valid_o <= vld_sd;
    end
  end

  always_ff @(posedge clk_i) begin
    eigen_major_o <= sideb_sd.eig.major;
    eigen_minor_o <= sideb_sd.eig.minor;
    if (sideb_sd.eig.diag) begin
      vec_row0_col0_o <= sideb_sd.eig.age ? one32 : '0;
      vec_row0_col1_o <= sideb_sd.eig.age ? '0 : one32;
      vec_row1_col0_o <= sideb_sd.eig.age ? '0 : one32;
      vec_row1_col1_o <= sideb_sd.eig.age ? one32 : '0;
    end else begin
      vec_row0_col0_o <= cs6_d;
      vec_row0_col1_o <= sn6_d;
      vec_row1_col0_o <= ~sn6_d + 32'd1;
      vec_row1_col1_o <= cs6_d;
    end
  end

`ifndef SYNTH
  a_beat_follows_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(start, TOTAL_LAT))
    else $error("result beat without a matching start");

  a_eig_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> ($signed(eigen_major_o) >= $signed(eigen_minor_o)))
    else $error("eigenvalues out of order");

  a_cos_nonneg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (!vec_row0_col0_o[31] && (vec_row0_col0_o == vec_row1_col1_o)))
    else $error("cosine term malformed");
`endif

endmodule
